// ===== sv/median_average_turbidity_defines.svh =====
// assertion macros for the turbidity block
`ifndef MEDIAN_AVERAGE_TURBIDITY_DEFINES_SVH
`define MEDIAN_AVERAGE_TURBIDITY_DEFINES_SVH
// a condition implies a consequence in the same cycle
`define MAT_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("%m: check failed");
// a condition implies a consequence in the next cycle
`define MAT_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("%m: check failed");
`endif

// ===== sv/mat_pkg.sv =====
// package: constants, types and tables for the turbidity block
package mat_pkg;
   localparam int MedianSize  = 5;
   localparam int AverageSize = 8;
   localparam int GroupIdxW   = $clog2(MedianSize + 1);
   localparam int RingIdxW    = (AverageSize > 1) ? $clog2(AverageSize) : 1;
   localparam int FillW       = $clog2(AverageSize + 1);
   localparam int TotalW      = 15 + $clog2(AverageSize + 1);
   localparam int TablePoints = 7;
   localparam int SortPasses  = MedianSize;
   localparam int PassW       = $clog2(MedianSize + 1);
   localparam int QuotW       = 29;
   localparam int QuotCntW    = $clog2(QuotW + 1);

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_SORT,
      ST_RING,
      ST_DIV_START,
      ST_DIV,
      ST_SEG,
      ST_MUL,
      ST_IDIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic store;
      logic sort_step;
      logic ring_update;
      logic div_start;
      logic div_step;
      logic seg_pick;
      logic mul;
      logic idiv_start;
      logic finish;
      logic clear_pass;
   } cmd_type;

   typedef struct packed {
      logic group_full;
      logic sort_done;
      logic div_done;
   } status_type;

   function automatic logic [16:0] tab_v(input int i);
      case (i)
         0: tab_v = 17'd65600;
         1: tab_v = 17'd59200;
         2: tab_v = 17'd57600;
         3: tab_v = 17'd54400;
         4: tab_v = 17'd40000;
         5: tab_v = 17'd32000;
         default: tab_v = 17'd0;
      endcase
   endfunction

   function automatic logic [10:0] tab_n(input int i);
      case (i)
         0: tab_n = 11'd0;
         1: tab_n = 11'd100;
         2: tab_n = 11'd200;
         3: tab_n = 11'd400;
         4: tab_n = 11'd800;
         5: tab_n = 11'd1200;
         default: tab_n = 11'd2000;
      endcase
   endfunction
endpackage

// ===== sv/mat_ctrl.sv =====
// controller state machine for the turbidity block
`include "median_average_turbidity_defines.svh"
module mat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mat_pkg::status_type status,
   output mat_pkg::cmd_type    cmd
);
   mat_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mat_pkg::ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mat_pkg::ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (status.group_full) begin
                  state_in = mat_pkg::ST_SORT;
               end
            end
         end
         mat_pkg::ST_SORT: begin
            cmd.sort_step = 1'b1;
            if (status.sort_done) begin
               state_in = mat_pkg::ST_RING;
            end
         end
         mat_pkg::ST_RING: begin
            cmd.ring_update = 1'b1;
            state_in = mat_pkg::ST_DIV_START;
         end
         mat_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = mat_pkg::ST_DIV;
         end
         mat_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = mat_pkg::ST_SEG;
            end
         end
         mat_pkg::ST_SEG: begin
            cmd.seg_pick = 1'b1;
            state_in = mat_pkg::ST_MUL;
         end
         mat_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            cmd.idiv_start = 1'b1;
            state_in = mat_pkg::ST_IDIV;
         end
         mat_pkg::ST_IDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = mat_pkg::ST_FINISH;
            end
         end
         mat_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = mat_pkg::ST_OUT;
         end
         mat_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear_pass = 1'b1;
            if (rsp_ready) begin
               state_in = mat_pkg::ST_COLLECT;
            end
         end
         default: state_in = mat_pkg::ST_COLLECT;
      endcase
   end

   `MAT_ASSERT_IMP(a_no_both, 1'b1, !(req_ready && rsp_valid))
   `MAT_ASSERT_NEXT(a_out_holds, rsp_valid && !rsp_ready, rsp_valid)
   `MAT_ASSERT_NEXT(a_full_sorts, req_valid && req_ready && status.group_full,
      state_ff == mat_pkg::ST_SORT)
endmodule

// ===== sv/mat_dp.sv =====
// datapath: group store, sorter, ring, divider and interpolation
module mat_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [15:0]  req_sample,
   input  mat_pkg::cmd_type    cmd,
   output mat_pkg::status_type status,
   output logic [14:0]         rsp_turbidity,
   output logic [14:0]         rsp_median_level,
   output logic [14:0]         rsp_average_level
);
   logic signed [15:0] grp_ff [mat_pkg::MedianSize];
   logic [mat_pkg::GroupIdxW-1:0] fill_ff;
   logic [mat_pkg::PassW-1:0] pass_ff;
   logic [14:0] ring_ff [mat_pkg::AverageSize];
   logic [mat_pkg::RingIdxW-1:0] pos_ff;
   logic [mat_pkg::FillW-1:0] filled_ff;
   logic [mat_pkg::TotalW-1:0] total_ff;
   logic [14:0] avg_ff;
   logic [14:0] ntu_ff;
   // shared restoring divider
   logic [mat_pkg::QuotW-1:0] num_ff;
   logic [16:0] den_ff;
   logic [17:0] rem_ff;
   logic [mat_pkg::QuotCntW-1:0] cnt_ff;
   // interpolation
   logic [16:0] v_ff, vlo_ff, span_ff;
   logic [10:0] nlo_ff, dn_ff;
   logic [1:0]  mode_ff;
   logic signed [15:0] mid;
   logic [16:0] vcomb;
   logic [17:0] rem_sh;
   logic [mat_pkg::FillW-1:0] filled_nx;
   logic [14:0] med_val;
   logic [14:0] med_hold_ff;
   logic avg_phase_ff;

   assign mid = grp_ff[mat_pkg::MedianSize / 2];
   assign med_val = mid[15] ? 15'd0 : mid[14:0];
   assign vcomb = {2'b00, avg_ff} * 17'd3;
   assign rem_sh = {rem_ff[16:0], num_ff[mat_pkg::QuotW-1]};
   assign status.group_full = (fill_ff == mat_pkg::GroupIdxW'(mat_pkg::MedianSize - 1));
   assign status.sort_done = (pass_ff == mat_pkg::PassW'(mat_pkg::SortPasses - 1));
   assign status.div_done = (cnt_ff == mat_pkg::QuotCntW'(1));
   assign filled_nx = (filled_ff < mat_pkg::FillW'(mat_pkg::AverageSize))
      ? filled_ff + 1'b1 : filled_ff;

   // odd-even transposition sort, one pass a cycle
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         grp_ff[fill_ff[mat_pkg::GroupIdxW-1:0]] <= req_sample;
      end
      if (cmd.sort_step) begin
         for (int i = 0; i + 1 < mat_pkg::MedianSize; i++) begin
            if ((i % 2) == int'(pass_ff[0]) && grp_ff[i] > grp_ff[i+1]) begin
               grp_ff[i]   <= grp_ff[i+1];
               grp_ff[i+1] <= grp_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pass_ff <= '0;
         pos_ff <= '0;
         filled_ff <= '0;
         total_ff <= '0;
         for (int i = 0; i < mat_pkg::AverageSize; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (cmd.store) begin
            fill_ff <= status.group_full ? '0 : fill_ff + 1'b1;
         end
         if (cmd.sort_step) begin
            pass_ff <= status.sort_done ? '0 : pass_ff + 1'b1;
         end
         if (cmd.ring_update) begin
            ring_ff[pos_ff] <= med_val;
            total_ff <= total_ff - mat_pkg::TotalW'(ring_ff[pos_ff])
               + mat_pkg::TotalW'(med_val);
            pos_ff <= (pos_ff == mat_pkg::RingIdxW'(mat_pkg::AverageSize - 1))
               ? '0 : pos_ff + 1'b1;
            filled_ff <= filled_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff  <= mat_pkg::QuotW'(total_ff);
         den_ff  <= 17'(filled_ff);
         rem_ff  <= '0;
         cnt_ff  <= mat_pkg::QuotCntW'(mat_pkg::QuotW);
      end else if (cmd.idiv_start) begin
         num_ff  <= mat_pkg::QuotW'(v_ff - vlo_ff) * mat_pkg::QuotW'(dn_ff)
            * mat_pkg::QuotW'(5'd16) + mat_pkg::QuotW'(span_ff[16:1]);
         den_ff  <= span_ff;
         rem_ff  <= '0;
         cnt_ff  <= mat_pkg::QuotCntW'(mat_pkg::QuotW);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            num_ff <= {num_ff[mat_pkg::QuotW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[mat_pkg::QuotW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.seg_pick) begin
         v_ff <= vcomb;
         mode_ff <= 2'd0;
         vlo_ff <= '0;
         span_ff <= 17'd1;
         nlo_ff <= '0;
         dn_ff <= '0;
         if (vcomb >= mat_pkg::tab_v(0)) begin
            mode_ff <= 2'd1;
         end else if (vcomb == 17'd0) begin
            mode_ff <= 2'd2;
         end else begin
            for (int i = mat_pkg::TablePoints - 2; i >= 0; i--) begin
               if (vcomb <= mat_pkg::tab_v(i) && vcomb > mat_pkg::tab_v(i + 1)) begin
                  vlo_ff  <= mat_pkg::tab_v(i + 1);
                  span_ff <= mat_pkg::tab_v(i) - mat_pkg::tab_v(i + 1);
                  nlo_ff  <= mat_pkg::tab_n(i + 1);
                  dn_ff   <= mat_pkg::tab_n(i + 1) - mat_pkg::tab_n(i);
               end
            end
         end
      end
      if (cmd.finish) begin
         unique case (mode_ff)
            2'd1: ntu_ff <= '0;
            2'd2: ntu_ff <= 15'd32000;
            default: ntu_ff <= 15'({nlo_ff, 4'd0} - num_ff[14:0]);
         endcase
      end
   end

   // median capture
   always_ff @(posedge clock) begin
      if (cmd.ring_update) begin
         med_hold_ff <= med_val;
      end
   end

   // average latched when the first division ends
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_phase_ff <= 1'b0;
      end else if (cmd.div_start) begin
         avg_phase_ff <= 1'b1;
      end else if (cmd.seg_pick) begin
         avg_phase_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (avg_phase_ff && cmd.div_step && status.div_done) begin
         avg_ff <= rem_sh >= {1'b0, den_ff} ? {num_ff[13:0], 1'b1} : {num_ff[13:0], 1'b0};
      end
   end

   assign rsp_turbidity = ntu_ff;
   assign rsp_median_level = med_hold_ff;
   assign rsp_average_level = avg_ff;
   logic unused_ok;
   assign unused_ok = cmd.clear_pass | cmd.mul;
endmodule

// ===== sv/median_average_turbidity.sv =====
// top level of the turbidity block
// Usage:
//  req channel: one signed 16-bit converter sample per transaction.
//  rsp channel: one result per group of five samples: turbidity (NTU in
//  Q11.4), clamped group median and moving average of medians.
//  A sample that does not complete a group is only stored; req_ready stays high.
//  The fifth sample starts processing: five odd-even sort passes, a ring
//  update, a 29-step restoring division for the average, segment choice,
//  one multiply and a second 29-step division for interpolation, both
//  divisions on the shared bit-serial divider.
//  req_ready is low while a group is processed and while a result waits.
//  If the receiver stalls, rsp_valid and the result hold until taken.
//  Reset clears the group count, the ring and the running total; the
//  block is ready for a sample in the cycle after reset falls.
module median_average_turbidity (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_turbidity,
   output logic [14:0]        rsp_median_level,
   output logic [14:0]        rsp_average_level
);
   mat_pkg::cmd_type    cmd;
   mat_pkg::status_type status;

   mat_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   mat_dp u_dp (
      .clock(clock), .reset(reset),
      .req_sample(req_sample), .cmd(cmd), .status(status),
      .rsp_turbidity(rsp_turbidity),
      .rsp_median_level(rsp_median_level),
      .rsp_average_level(rsp_average_level)
   );
endmodule
